>>> src/svms_pkg.sv
package svms_pkg;

  localparam int MAX_RECORDS    = 64;
  localparam int SIGN_POSITIONS = 16;
  localparam int MAX_KEYS       = 8;

  localparam int SIGNS_W     = 32;
  localparam int ARRIVAL_W   = 6;
  localparam int KEY_COUNT_W = 4;
  localparam int POS_W       = 4;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_POSITIONS = 1'b1;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  // Rank of a sign: 0 for -1, 1 for 0, 2 for +1. Code 3 ranks as +1, and a
  // position outside the vector reads as sign 0.
  function automatic logic [1:0] sign_rank(input logic [SIGNS_W-1:0] rec,
                                           input logic [POS_W-1:0] pos);
    logic [1:0] code;
    code = rec[{pos, 1'b0} +: 2];
    if (32'(pos) >= SIGN_POSITIONS) begin
      return 2'd1;
    end
    return code[1] ? 2'd2 : code;
  endfunction

endpackage

>>> src/svms_in_if.sv
interface svms_in_if;
  logic                          valid;
  logic                          ready;
  logic [svms_pkg::SIGNS_W-1:0]  signs;
  logic                          last;

  modport source(output valid, output signs, output last, input ready);
  modport sink(input valid, input signs, input last, output ready);
endinterface

>>> src/svms_out_if.sv
interface svms_out_if;
  logic                           valid;
  logic                           ready;
  logic [svms_pkg::SIGNS_W-1:0]   sorted_signs;
  logic [svms_pkg::ARRIVAL_W-1:0] arrival_index;
  logic                           overflow;
  logic                           last_out;

  modport source(output valid, output sorted_signs, output arrival_index,
                 output overflow, output last_out, input ready);
  modport sink(input valid, input sorted_signs, input arrival_index,
               input overflow, input last_out, output ready);
endinterface

>>> src/sign_vector_multikey_sort.sv
// Channel   Dir   Payload                                         Accepted when
// rec_in    in    signs, last                                     valid && ready
// res_out   out   sorted_signs, arrival_index, overflow, last_out valid && ready
// cfg       in    cfg_we, cfg_index, cfg_data                     cfg_we
//
// A record without last is stored (past capacity it is dropped and flagged as overflow) and the block stays ready.
// A last record starts the sort, one compare per cycle on the shared comparator
// for each pair of stored records, while rec_in.ready stays low. Each result then
// passes S_EO, S_ER and S_EV, and waits in S_EV while the output is full and res_out.ready is low.
// Reset is synchronous on rst; it clears the state, counters, configuration and output valid flag.
module sign_vector_multikey_sort (
  input  logic                              clk,
  input  logic                              rst,
  svms_in_if.sink                           rec_in,
  svms_out_if.source                        res_out,
  input  logic                              cfg_we,
  input  logic [svms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = svms_pkg::IDX_W;
  localparam int CNT_W = svms_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_LOAD, S_RD_I, S_LAT_I, S_SCAN, S_EO, S_ER, S_EV
  } state_t;

  state_t state;

  logic [svms_pkg::KEY_COUNT_W-1:0]                     key_count;
  logic [svms_pkg::MAX_KEYS*svms_pkg::POS_W-1:0]        key_positions;

  logic [svms_pkg::SIGNS_W-1:0] record_mem [svms_pkg::MAX_RECORDS];
  logic [IDX_W-1:0]             order_mem  [svms_pkg::MAX_RECORDS];

  logic [CNT_W-1:0]             total;
  logic                         overflow_seen;
  logic [CNT_W-1:0]             i;
  logic [CNT_W-1:0]             j;
  logic [CNT_W-1:0]             k;
  logic [CNT_W-1:0]             rank;
  logic [CNT_W-1:0]             rank_next;
  logic [svms_pkg::SIGNS_W-1:0] rec_i;
  logic [IDX_W-1:0]             rd_addr;
  logic [svms_pkg::SIGNS_W-1:0] rd_data;
  logic [IDX_W-1:0]             ord_q;

  logic                         out_valid;
  logic [svms_pkg::SIGNS_W-1:0] out_signs;
  logic [svms_pkg::ARRIVAL_W-1:0] out_index;
  logic                         out_ovf;
  logic                         out_last;

  logic                         in_acc;
  logic                         out_acc;
  logic                         scan_last;
  logic                         goes_ahead;
  svms_pkg::cmp_res_t           cmp;

  assign in_acc    = rec_in.valid && rec_in.ready;
  assign out_acc   = out_valid && res_out.ready;
  assign scan_last = (j + CNT_W'(1)) == total;

  assign rec_in.ready          = (state == S_LOAD);
  assign res_out.valid         = out_valid;
  assign res_out.sorted_signs  = out_signs;
  assign res_out.arrival_index = out_index;
  assign res_out.overflow      = out_ovf;
  assign res_out.last_out      = out_last;

  svms_cmp u_cmp (
    .a             (rd_data),
    .b             (rec_i),
    .key_count     (key_count),
    .key_positions (key_positions),
    .res           (cmp)
  );

  // Record j goes ahead of record i if its key is smaller, or equal with an
  // earlier arrival; the count of such records is the sorted slot of i.
  assign goes_ahead = cmp.lt || (cmp.eq && (j < i));
  assign rank_next  = rank + CNT_W'(goes_ahead);

  always_comb begin
    case (state)
      S_RD_I:  rd_addr = i[IDX_W-1:0];
      S_LAT_I: rd_addr = '0;
      S_SCAN:  rd_addr = scan_last ? IDX_W'(i + CNT_W'(1)) : IDX_W'(j + CNT_W'(1));
      S_ER:    rd_addr = ord_q;
      S_EV:    rd_addr = ord_q;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (total < CNT_W'(svms_pkg::MAX_RECORDS))) begin
      record_mem[total[IDX_W-1:0]] <= rec_in.signs;
    end
    rd_data <= record_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && scan_last) begin
      order_mem[rank_next[IDX_W-1:0]] <= i[IDX_W-1:0];
    end
    if (state == S_EO) begin
      ord_q <= order_mem[k[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      key_positions <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        svms_pkg::CFG_KEY_COUNT:     key_count <= cfg_data[svms_pkg::KEY_COUNT_W-1:0];
        svms_pkg::CFG_KEY_POSITIONS: key_positions <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      total         <= '0;
      overflow_seen <= 1'b0;
      i             <= '0;
      j             <= '0;
      k             <= '0;
      rank          <= '0;
      out_valid     <= 1'b0;
    end else begin
      // In S_EV an accepted result is always replaced by the next one below.
      if (out_acc && (state != S_EV)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (total < CNT_W'(svms_pkg::MAX_RECORDS)) begin
              total <= total + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (rec_in.last) begin
              i     <= '0;
              state <= S_RD_I;
            end
          end
        end
        S_RD_I: begin
          state <= S_LAT_I;
        end
        S_LAT_I: begin
          rec_i <= rd_data;
          j     <= '0;
          rank  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          rank <= rank_next;
          j    <= j + CNT_W'(1);
          if (scan_last) begin
            i <= i + CNT_W'(1);
            if ((i + CNT_W'(1)) == total) begin
              k     <= '0;
              state <= S_EO;
            end else begin
              state <= S_LAT_I;
            end
          end
        end
        S_EO: begin
          state <= S_ER;
        end
        S_ER: begin
          state <= S_EV;
        end
        S_EV: begin
          if (!out_valid || res_out.ready) begin
            out_valid <= 1'b1;
            out_signs <= rd_data;
            out_index <= svms_pkg::ARRIVAL_W'(ord_q);
            out_ovf   <= overflow_seen;
            out_last  <= (k + CNT_W'(1)) == total;
            k         <= k + CNT_W'(1);
            if ((k + CNT_W'(1)) == total) begin
              total         <= '0;
              overflow_seen <= 1'b0;
              state         <= S_LOAD;
            end else begin
              state <= S_EO;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(svms_pkg::MAX_RECORDS))
    else $error("stored record count above capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ((j < total) && (i < total)))
    else $error("scan index outside stored records");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && scan_last) |-> (rank_next < total))
    else $error("sorted slot outside stored records");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_acc && rec_in.last) |=> !rec_in.ready)
    else $error("input still taken after a final record");

  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EV) && $past(state) == S_EV && !out_valid) |-> 1'b0)
    else $error("emission stalled with a free output register");

endmodule

>>> src/svms_cmp.sv
module svms_cmp (
  input  logic [svms_pkg::SIGNS_W-1:0]             a,
  input  logic [svms_pkg::SIGNS_W-1:0]             b,
  input  logic [svms_pkg::KEY_COUNT_W-1:0]         key_count,
  input  logic [svms_pkg::MAX_KEYS*svms_pkg::POS_W-1:0] key_positions,
  output svms_pkg::cmp_res_t                       res
);

  logic [svms_pkg::KEY_COUNT_W-1:0] n_keys;

  assign n_keys = (key_count > svms_pkg::KEY_COUNT_W'(svms_pkg::MAX_KEYS))
                  ? svms_pkg::KEY_COUNT_W'(svms_pkg::MAX_KEYS) : key_count;

  // Walk keys from lowest to highest priority so the first differing key wins.
  always_comb begin
    res.lt = 1'b0;
    res.eq = 1'b1;
    for (int k = svms_pkg::MAX_KEYS - 1; k >= 0; k--) begin
      if ((svms_pkg::KEY_COUNT_W'(k) < n_keys) &&
          (svms_pkg::sign_rank(a, key_positions[k*svms_pkg::POS_W +: svms_pkg::POS_W]) !=
           svms_pkg::sign_rank(b, key_positions[k*svms_pkg::POS_W +: svms_pkg::POS_W]))) begin
        res.lt = svms_pkg::sign_rank(a, key_positions[k*svms_pkg::POS_W +: svms_pkg::POS_W]) <
                 svms_pkg::sign_rank(b, key_positions[k*svms_pkg::POS_W +: svms_pkg::POS_W]);
        res.eq = 1'b0;
      end
    end
  end

endmodule
